>>> hw/rtl/dsf_pkg.sv
// ----------------------------------------------------------------------------
// Damped spring force package
// Shared widths, register indexes and helpers for the spring force pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package dsf_pkg;

  localparam int DATA_W        = 32;
  localparam int DIFF_W        = DATA_W + 1;
  localparam int SQ_W          = 2 * DIFF_W;
  localparam int LEN_W         = SQ_W / 2;
  localparam int REM_W         = LEN_W + 3;
  localparam int EXT_W         = LEN_W + 1;
  localparam int REST_W        = 31;
  localparam int CFG_IDX_W     = 2;
  localparam int DEF_FRAC_BITS = 16;

  localparam logic [CFG_IDX_W-1:0] REG_STIFFNESS   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_REST_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING     = 2'd2;

  typedef logic signed [DIFF_W-1:0] diff_t;

  // Magnitude of a coordinate difference; it never reaches the negative limit.
  function automatic logic [DIFF_W-1:0] mag_of(diff_t v);
    logic [DIFF_W-1:0] m;
    m = v[DIFF_W-1] ? DIFF_W'(-v) : DIFF_W'(v);
    return m;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/dsf_delay.sv
// ----------------------------------------------------------------------------
// Side data delay line
// Carries data alongside a pipelined unit so that it arrives aligned.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_delay #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             en,
  input  wire logic [WIDTH-1:0] din,
  output logic      [WIDTH-1:0] dout
);

  logic [WIDTH-1:0] line [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      line[0] <= din;
      for (int k = 1; k < DEPTH; k++) begin
        line[k] <= line[k-1];
      end
    end
  end

  assign dout = line[DEPTH-1];

endmodule

`default_nettype wire

>>> hw/rtl/dsf_sqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// Digit-by-digit floor square root, one result bit per register stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_sqrt (
  input  wire logic                       clk,
  input  wire logic                       en,
  input  wire logic [dsf_pkg::SQ_W-1:0]   rad_in,
  output logic      [dsf_pkg::LEN_W-1:0]  root_out
);

  import dsf_pkg::*;

  logic [SQ_W-1:0]  rad_q  [LEN_W];
  logic [REM_W-1:0] rem_q  [LEN_W];
  logic [LEN_W-1:0] root_q [LEN_W];

  for (genvar k = 0; k < LEN_W; k++) begin : g_step
    logic [SQ_W-1:0]  rad_prev;
    logic [REM_W-1:0] rem_prev;
    logic [LEN_W-1:0] root_prev;
    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fit;

    if (k == 0) begin : g_first
      assign rad_prev  = rad_in;
      assign rem_prev  = '0;
      assign root_prev = '0;
    end else begin : g_rest
      assign rad_prev  = rad_q[k-1];
      assign rem_prev  = rem_q[k-1];
      assign root_prev = root_q[k-1];
    end

    // Bring down the next two radicand bits and try root*4+1.
    assign rem_sh = {rem_prev[REM_W-3:0], rad_prev[SQ_W-1 -: 2]};
    assign trial  = {1'b0, root_prev, 2'b01};
    assign fit    = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        rad_q[k]  <= rad_prev << 2;
        rem_q[k]  <= fit ? rem_sh - trial : rem_sh;
        root_q[k] <= {root_prev[LEN_W-2:0], fit};
      end
    end
  end

  assign root_out = root_q[LEN_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/dsf_div.sv
// ----------------------------------------------------------------------------
// Pipelined unit-vector divider
// Restoring division of a scaled magnitude by the length, one bit per stage.
// ----------------------------------------------------------------------------
`default_nettype none

module dsf_div #(
  parameter int FRAC_BITS = dsf_pkg::DEF_FRAC_BITS
) (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [dsf_pkg::DIFF_W-1:0]  num_mag,
  input  wire logic [dsf_pkg::LEN_W-1:0]   den,
  output logic      [FRAC_BITS:0]          quo
);

  import dsf_pkg::*;

  localparam int NUM_W = DIFF_W + FRAC_BITS;
  localparam int Q_W   = FRAC_BITS + 1;

  logic [NUM_W-1:0] rem_q [Q_W];
  logic [LEN_W-1:0] den_q [Q_W];
  logic [Q_W-1:0]   quo_q [Q_W];

  // The magnitude never exceeds the length, so the quotient fits in Q_W bits.
  for (genvar s = 0; s < Q_W; s++) begin : g_step
    logic [NUM_W-1:0] rem_prev;
    logic [LEN_W-1:0] den_prev;
    logic [Q_W-1:0]   quo_prev;
    logic [NUM_W-1:0] dsh;
    logic             fit;

    if (s == 0) begin : g_first
      assign rem_prev = {num_mag, {FRAC_BITS{1'b0}}};
      assign den_prev = den;
      assign quo_prev = '0;
    end else begin : g_rest
      assign rem_prev = rem_q[s-1];
      assign den_prev = den_q[s-1];
      assign quo_prev = quo_q[s-1];
    end

    assign dsh = NUM_W'(den_prev) << (FRAC_BITS - s);
    assign fit = rem_prev >= dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[s] <= fit ? rem_prev - dsh : rem_prev;
        den_q[s] <= den_prev;
        quo_q[s] <= {quo_prev[Q_W-2:0], fit};
      end
    end
  end

  assign quo = quo_q[Q_W-1];

endmodule

`default_nettype wire

>>> hw/rtl/damped_spring_force_unit.sv
// ----------------------------------------------------------------------------
// Damped spring force unit
// Spring plus half damping force between two particles, signed fixed point.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel item_valid/item_stall carries the positions and velocities
//   of both particles; a transfer happens when item_valid is high and
//   item_stall is low. Output channel force_valid/force_stall returns the
//   saturated force on the first particle and the null_force flag.
//   Each transfer in gives exactly one transfer out, in order.
//   The pipeline has three input stages, 33 square root stages (one per
//   length bit), FRAC_BITS + 1 divider stages (one per unit vector bit)
//   and six force stages.
//   Throughput is one item per cycle while the pipeline is not frozen.
//   When the receiver holds force_stall with a result waiting, the whole
//   pipeline freezes and item_stall rises; nothing is dropped or repeated.
//   Reset empties the pipeline and loads stiffness = 1.0, rest_length = 1.0
//   and damping = 0. Write the registers through cfg_write only while the
//   pipeline is empty.
// ----------------------------------------------------------------------------
`default_nettype none

module damped_spring_force_unit #(
  parameter int FRAC_BITS = dsf_pkg::DEF_FRAC_BITS
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_write,
  input  wire logic [dsf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [dsf_pkg::DATA_W-1:0]     cfg_data,
  input  wire logic                           item_valid,
  output logic                                item_stall,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_pos_x,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_pos_y,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_pos_z,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_pos_x,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_pos_y,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_pos_z,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_vel_x,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_vel_y,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] first_vel_z,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_vel_x,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_vel_y,
  input  wire logic signed [dsf_pkg::DATA_W-1:0] second_vel_z,
  output logic                                force_valid,
  input  wire logic                           force_stall,
  output logic signed [dsf_pkg::DATA_W-1:0]   force_x,
  output logic signed [dsf_pkg::DATA_W-1:0]   force_y,
  output logic signed [dsf_pkg::DATA_W-1:0]   force_z,
  output logic                                null_force
);

  import dsf_pkg::*;

  localparam int U_W     = FRAC_BITS + 2;
  localparam int PROD_W  = DIFF_W + U_W;
  localparam int DOT_W   = PROD_W + 2;
  localparam int PROJ_W  = DOT_W - FRAC_BITS;
  localparam int T_W     = 72;
  localparam int SC_W    = FRAC_BITS + 34;
  localparam int LO_W    = DATA_W + 1 + U_W;
  localparam int HI_W    = 2 * U_W;
  localparam int P_W     = SC_W + U_W;
  localparam int NST     = LEN_W + FRAC_BITS + 10;
  localparam int EPS_RAW = ((1 << FRAC_BITS) + 999999) / 1000000;
  localparam int SIDE1_W = 6 * DIFF_W;
  localparam int SIDE2_W = 3 * DIFF_W + 3 + LEN_W;

  localparam logic signed [T_W-1:0] SC_LIM =
    {{(T_W-FRAC_BITS-33){1'b0}}, 1'b1, {(FRAC_BITS+32){1'b0}}};
  localparam logic signed [P_W-1:0] SAT_MAX = {{(P_W-31){1'b0}}, {31{1'b1}}};
  localparam logic signed [P_W-1:0] SAT_MIN = {{(P_W-31){1'b1}}, {31{1'b0}}};

  logic [DATA_W-1:0] stiffness;
  logic [REST_W-1:0] rest_length;
  logic [DATA_W-1:0] damping;

  logic           en;
  logic [NST-1:0] vld;

  logic signed [DATA_W-1:0] pos1 [3];
  logic signed [DATA_W-1:0] pos2 [3];
  logic signed [DATA_W-1:0] vel1 [3];
  logic signed [DATA_W-1:0] vel2 [3];

  diff_t           d_a  [3];
  diff_t           dv_a [3];
  diff_t           d_b  [3];
  diff_t           dv_b [3];
  logic [SQ_W-1:0] sq_b [3];
  diff_t           d_c  [3];
  diff_t           dv_c [3];
  logic [SQ_W-1:0] sq_c;

  logic [SIDE1_W-1:0] side1_in;
  logic [SIDE1_W-1:0] side1_out;
  logic [LEN_W-1:0]   len_s;
  diff_t              d_s  [3];
  diff_t              dv_s [3];

  logic [FRAC_BITS:0] quo [3];
  logic [SIDE2_W-1:0] side2_in;
  logic [SIDE2_W-1:0] side2_out;
  diff_t              dv_q  [3];
  logic               neg_q [3];
  logic [LEN_W-1:0]   len_q;

  logic signed [U_W-1:0]    u_c    [3];
  logic signed [U_W-1:0]    u_e    [3];
  logic signed [PROD_W-1:0] prod_e [3];
  logic [LEN_W-1:0]         len_e;

  logic signed [DOT_W-1:0]  dot;
  logic signed [PROJ_W-1:0] proj_f;
  logic signed [EXT_W-1:0]  ext_f;
  logic signed [U_W-1:0]    u_f [3];
  logic                     null_f;

  logic signed [T_W-1:0] pk_g;
  logic signed [T_W-1:0] pc_g;
  logic signed [U_W-1:0] u_g [3];
  logic                  null_g;

  logic signed [T_W-1:0]  tneg;
  logic signed [T_W-1:0]  tsh;
  logic signed [T_W-1:0]  tclamp;
  logic signed [SC_W-1:0] sc_h;
  logic signed [U_W-1:0]  u_h [3];
  logic                   null_h;

  logic signed [LO_W-1:0] plo_i [3];
  logic signed [HI_W-1:0] phi_i [3];
  logic                   null_i;

  logic signed [P_W-1:0]    p_full [3];
  logic signed [P_W-1:0]    q_full [3];
  logic signed [DATA_W-1:0] sat    [3];

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      stiffness   <= DATA_W'(1) << FRAC_BITS;
      rest_length <= REST_W'(1) << FRAC_BITS;
      damping     <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_STIFFNESS:   stiffness   <= cfg_data;
        REG_REST_LENGTH: rest_length <= cfg_data[REST_W-1:0];
        REG_DAMPING:     damping     <= cfg_data;
        default:         ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Flow control: every stage advances together unless a result is held.
  // --------------------------------------------------------------------------
  assign en          = !(vld[NST-1] && force_stall);
  assign item_stall  = !en;
  assign force_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NST-2:0], item_valid};
    end
  end

  assign pos1 = '{first_pos_x, first_pos_y, first_pos_z};
  assign pos2 = '{second_pos_x, second_pos_y, second_pos_z};
  assign vel1 = '{first_vel_x, first_vel_y, first_vel_z};
  assign vel2 = '{second_vel_x, second_vel_y, second_vel_z};

  // --------------------------------------------------------------------------
  // Separation, squares and squared length
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        d_a[i]  <= diff_t'(pos1[i]) - diff_t'(pos2[i]);
        dv_a[i] <= diff_t'(vel1[i]) - diff_t'(vel2[i]);
        d_b[i]  <= d_a[i];
        dv_b[i] <= dv_a[i];
        sq_b[i] <= mag_of(d_a[i]) * mag_of(d_a[i]);
        d_c[i]  <= d_b[i];
        dv_c[i] <= dv_b[i];
      end
      sq_c <= sq_b[0] + sq_b[1] + sq_b[2];
    end
  end

  // --------------------------------------------------------------------------
  // Length by square root, separation carried alongside
  // --------------------------------------------------------------------------
  dsf_sqrt u_sqrt (
    .clk      (clk),
    .en       (en),
    .rad_in   (sq_c),
    .root_out (len_s)
  );

  assign side1_in = {d_c[0], d_c[1], d_c[2], dv_c[0], dv_c[1], dv_c[2]};

  dsf_delay #(
    .WIDTH (SIDE1_W),
    .DEPTH (LEN_W)
  ) u_side1 (
    .clk  (clk),
    .en   (en),
    .din  (side1_in),
    .dout (side1_out)
  );

  assign {d_s[0], d_s[1], d_s[2], dv_s[0], dv_s[1], dv_s[2]} = side1_out;

  // --------------------------------------------------------------------------
  // Unit direction magnitudes, one divider per axis
  // --------------------------------------------------------------------------
  for (genvar i = 0; i < 3; i++) begin : g_div
    dsf_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk     (clk),
      .en      (en),
      .num_mag (mag_of(d_s[i])),
      .den     (len_s),
      .quo     (quo[i])
    );
  end

  assign side2_in = {dv_s[0], dv_s[1], dv_s[2], d_s[0][DIFF_W-1], d_s[1][DIFF_W-1],
                     d_s[2][DIFF_W-1], len_s};

  dsf_delay #(
    .WIDTH (SIDE2_W),
    .DEPTH (FRAC_BITS + 1)
  ) u_side2 (
    .clk  (clk),
    .en   (en),
    .din  (side2_in),
    .dout (side2_out)
  );

  assign {dv_q[0], dv_q[1], dv_q[2], neg_q[0], neg_q[1], neg_q[2], len_q} = side2_out;

  // --------------------------------------------------------------------------
  // Force stages
  // --------------------------------------------------------------------------
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      u_c[i] = neg_q[i] ? -$signed({1'b0, quo[i]}) : $signed({1'b0, quo[i]});
    end
  end

  assign dot = DOT_W'(prod_e[0]) + DOT_W'(prod_e[1]) + DOT_W'(prod_e[2]);

  // The scalar is negated and floored here; beyond the clamp every nonzero
  // direction component saturates anyway, so the clamp changes no result.
  always_comb begin
    tneg = -(pk_g + pc_g);
    tsh  = tneg >>> (FRAC_BITS + 1);
    if (tsh > SC_LIM) begin
      tclamp = SC_LIM;
    end else if (tsh < -SC_LIM) begin
      tclamp = -SC_LIM;
    end else begin
      tclamp = tsh;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      p_full[i] = (P_W'(phi_i[i]) <<< DATA_W) + P_W'(plo_i[i]);
      q_full[i] = p_full[i] >>> FRAC_BITS;
      if (q_full[i] > SAT_MAX) begin
        sat[i] = SAT_MAX[DATA_W-1:0];
      end else if (q_full[i] < SAT_MIN) begin
        sat[i] = SAT_MIN[DATA_W-1:0];
      end else begin
        sat[i] = q_full[i][DATA_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        u_e[i]    <= u_c[i];
        prod_e[i] <= dv_q[i] * u_c[i];
        u_f[i]    <= u_e[i];
        u_g[i]    <= u_f[i];
        u_h[i]    <= u_g[i];
        // The scalar is split into a low unsigned word and a signed top part.
        plo_i[i]  <= $signed({1'b0, sc_h[DATA_W-1:0]}) * u_h[i];
        phi_i[i]  <= $signed(sc_h[SC_W-1:DATA_W]) * u_h[i];
      end
      len_e  <= len_q;

      proj_f <= PROJ_W'(dot >>> FRAC_BITS);
      ext_f  <= $signed({1'b0, len_e}) - $signed({3'b000, rest_length});
      null_f <= len_e < LEN_W'(EPS_RAW);

      pk_g   <= $signed({1'b0, stiffness, 1'b0}) * ext_f;
      pc_g   <= $signed({1'b0, damping}) * proj_f;
      null_g <= null_f;

      sc_h   <= SC_W'(tclamp);
      null_h <= null_g;

      null_i <= null_h;

      force_x    <= null_i ? '0 : sat[0];
      force_y    <= null_i ? '0 : sat[1];
      force_z    <= null_i ? '0 : sat[2];
      null_force <= null_i;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_null_zero : assert property (@(posedge clk) disable iff (rst)
    force_valid && null_force |-> force_x == 0 && force_y == 0 && force_z == 0)
    else $error("null force result carries a nonzero component");

  a_accept_enters : assert property (@(posedge clk) disable iff (rst)
    item_valid && !item_stall |=> vld[0])
    else $error("accepted transfer did not enter the pipeline");

  a_frozen : assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(vld))
    else $error("pipeline valid bits moved while frozen");

endmodule

`default_nettype wire
